// ===== hdl/inverse_cdf_interpolator_defines.svh =====
// Assertion macros shared by the inverse CDF interpolator RTL
`ifndef INVERSE_CDF_INTERPOLATOR_DEFINES_SVH
`define INVERSE_CDF_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define ICDF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ICDF_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ICDF_ASSERT(lbl, clk, rst, prop, msg)

`define ICDF_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ===== hdl/icdf_pkg.sv =====
// Shared types and constants of the inverse CDF interpolator
`timescale 1ns / 1ps
`default_nettype none

package icdf_pkg;

   localparam int MAX_POINTS_DEF     = 256;
   localparam int PROB_FRAC_BITS_DEF = 16;
   localparam int VALUE_W            = 32;
   localparam int OPCODE_W           = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_LAST,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_ERR,
      RES_RDATA,
      RES_INTERP
   } res_sel_type;

   typedef struct packed {
      logic        wr_en;
      logic        clr;
      logic        q_load;
      rd_sel_type  rd_sel;
      logic        idx_clr;
      logic        idx_inc;
      logic        lo_load;
      logic        hi_load;
      logic        mul_go;
      logic        div_go;
      logic        res_load;
      res_sel_type res_sel;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic count_full;
      logic count_lt2;
      logic q_le0;
      logic q_ge1;
      logic hit;
      logic idx_zero;
      logic idx_last;
      logic div_done;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== hdl/icdf_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands
`timescale 1ns / 1ps
`default_nettype none
`include "inverse_cdf_interpolator_defines.svh"

module icdf_div #(
   parameter int DVW = 48,
   parameter int DSW = 17
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [DVW-1:0] dividend,
   input  wire logic [DSW-1:0] divisor,
   output logic                done,
   output logic      [DVW-1:0] quotient
);

   localparam int CNTW = $clog2(DVW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DVW-1:0]  quo_ff, quo_in;
   logic [DSW-1:0]  rem_ff, rem_in;
   logic [DSW-1:0]  den_ff, den_in;
   logic [DSW:0]    trial;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVW-1]} - {1'b0, den_ff};
      ge      = !trial[DSW];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(DVW - 1);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVW-2:0], ge};
         rem_in = ge ? trial[DSW-1:0] : {rem_ff[DSW-2:0], quo_ff[DVW-1]};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `ICDF_ASSERT_NEVER(a_start_while_busy, clock, reset, start && busy_ff, "divider restarted while busy")
   `ICDF_ASSERT(a_rem_below_den, clock, reset, busy_ff |-> (rem_ff < den_ff), "partial remainder not below divisor")

endmodule

`default_nettype wire

// ===== hdl/icdf_dp.sv =====
// Datapath: breakpoint memory, search registers, multiply, divide and result register
`timescale 1ns / 1ps
`default_nettype none
`include "inverse_cdf_interpolator_defines.svh"

module icdf_dp #(
   parameter int MAX_POINTS     = icdf_pkg::MAX_POINTS_DEF,
   parameter int PROB_FRAC_BITS = icdf_pkg::PROB_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire icdf_pkg::cmd_type                 cmd,
   output icdf_pkg::sts_type                      sts,
   input  wire logic [icdf_pkg::VALUE_W-1:0]      point_value,
   input  wire logic [PROB_FRAC_BITS:0]           point_prob,
   input  wire logic signed [PROB_FRAC_BITS+2:0]  query_prob,
   input  wire logic                              rsp_tready,
   output logic                                   rsp_tvalid,
   output logic [icdf_pkg::VALUE_W-1:0]           rsp_quantile,
   output logic                                   rsp_table_error
);

   localparam int VW  = icdf_pkg::VALUE_W;
   localparam int PW  = PROB_FRAC_BITS + 1;
   localparam int QW  = PROB_FRAC_BITS + 3;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int AW  = $clog2(MAX_POINTS);
   localparam int DFW = VW + 1;
   localparam int PRW = DFW + PW + 1;
   localparam int MW  = VW + PROB_FRAC_BITS;
   localparam logic [QW-1:0] Q_ONE = {{(QW-PW){1'b0}}, 1'b1, {PROB_FRAC_BITS{1'b0}}};

   logic [VW+PW-1:0]        bp_mem_ff [MAX_POINTS];
   logic [VW+PW-1:0]        rdata_ff;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           last_cnt;
   logic [AW-1:0]           idx_ff;
   logic [AW-1:0]           rd_addr;
   logic signed [QW-1:0]    q_ff;
   logic [VW-1:0]           rd_v;
   logic [PW-1:0]           rd_p;
   logic [VW-1:0]           lo_v_ff;
   logic [PW-1:0]           lo_p_ff;
   logic signed [DFW-1:0]   diff_ff, diff_in;
   logic [PW-1:0]           frac_ff, frac_in;
   logic [PW-1:0]           den_ff, den_in;
   logic signed [PRW-1:0]   prod_ff, prod_in;
   logic [PRW-1:0]          prod_abs;
   logic [MW-1:0]           quo;
   logic                    div_done;
   logic [VW-1:0]           quo_signed;
   logic [VW-1:0]           res_ff, res_in;
   logic                    res_err_ff, res_err_in;
   logic                    rsp_valid_ff;
   logic                    rsp_free;

   assign rd_v     = rdata_ff[VW-1:0];
   assign rd_p     = rdata_ff[VW+PW-1:VW];
   assign last_cnt = count_ff - CW'(1);

   always_comb begin
      case (cmd.rd_sel)
         icdf_pkg::RD_ZERO: rd_addr = '0;
         icdf_pkg::RD_LAST: rd_addr = last_cnt[AW-1:0];
         default:           rd_addr = idx_ff + AW'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         bp_mem_ff[count_ff[AW-1:0]] <= {point_prob, point_value};
      end
      rdata_ff <= bp_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clr) begin
         count_ff <= '0;
      end else if (cmd.wr_en) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + AW'(1);
      end
   end

   // interval set-up straight from the bracketing upper entry
   always_comb begin
      diff_in = $signed({rd_v[VW-1], rd_v}) - $signed({lo_v_ff[VW-1], lo_v_ff});
      frac_in = q_ff[PW-1:0] - lo_p_ff;
      den_in  = rd_p - lo_p_ff;
      prod_in = diff_ff * $signed({1'b0, frac_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.q_load) begin
         q_ff <= query_prob;
      end
      if (cmd.lo_load) begin
         lo_v_ff <= rd_v;
         lo_p_ff <= rd_p;
      end
      if (cmd.hi_load) begin
         diff_ff <= diff_in;
         frac_ff <= frac_in;
         den_ff  <= den_in;
      end
      if (cmd.mul_go) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_abs = prod_ff[PRW-1] ? PRW'(-prod_ff) : PRW'(prod_ff);

   icdf_div #(
      .DVW (MW),
      .DSW (PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (prod_abs[MW-1:0]),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign quo_signed = prod_ff[PRW-1] ? (-quo[VW-1:0]) : quo[VW-1:0];

   always_comb begin
      case (cmd.res_sel)
         icdf_pkg::RES_ERR: begin
            res_in     = '0;
            res_err_in = 1'b1;
         end
         icdf_pkg::RES_RDATA: begin
            res_in     = rd_v;
            res_err_in = 1'b0;
         end
         default: begin
            res_in     = lo_v_ff + quo_signed;
            res_err_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_ff     <= res_in;
         res_err_ff <= res_err_in;
      end
      if (cmd.rsp_load) begin
         rsp_quantile    <= res_ff;
         rsp_table_error <= res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      sts.count_full = (count_ff == CW'(MAX_POINTS));
      sts.count_lt2  = (count_ff < CW'(2));
      sts.q_le0      = query_prob[QW-1] || (query_prob == '0);
      sts.q_ge1      = !query_prob[QW-1] && (query_prob >= Q_ONE);
      sts.hit        = $signed({2'b00, rd_p}) > q_ff;
      sts.idx_zero   = (idx_ff == '0);
      sts.idx_last   = (CW'(idx_ff) == last_cnt);
      sts.div_done   = div_done;
      sts.rsp_free   = rsp_free;
   end

   `ICDF_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_POINTS), "entry count beyond capacity")
   `ICDF_ASSERT(a_rsp_slot_free, clock, reset, cmd.rsp_load |-> rsp_free, "result word overwritten")

endmodule

`default_nettype wire

// ===== hdl/icdf_ctrl.sv =====
// Controller: decodes each request word and sequences the search and interpolation
`timescale 1ns / 1ps
`default_nettype none

module icdf_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic [icdf_pkg::OPCODE_W-1:0]  req_opcode,
   output logic                                req_tready,
   input  wire icdf_pkg::sts_type              sts,
   output icdf_pkg::cmd_type                   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      cmd.rd_sel  = icdf_pkg::RD_NEXT;
      cmd.res_sel = icdf_pkg::RES_RDATA;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_opcode)
                  icdf_pkg::OP_APPEND: cmd.wr_en = !sts.count_full;
                  icdf_pkg::OP_CLEAR:  cmd.clr = 1'b1;
                  icdf_pkg::OP_QUERY: begin
                     cmd.q_load = 1'b1;
                     if (sts.count_lt2) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = icdf_pkg::RES_ERR;
                        state_in     = ST_OUT;
                     end else if (sts.q_le0) begin
                        cmd.rd_sel = icdf_pkg::RD_ZERO;
                        state_in   = ST_LOAD;
                     end else if (sts.q_ge1) begin
                        cmd.rd_sel = icdf_pkg::RD_LAST;
                        state_in   = ST_LOAD;
                     end else begin
                        cmd.rd_sel  = icdf_pkg::RD_ZERO;
                        cmd.idx_clr = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.res_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_SCAN: begin
            if (sts.hit) begin
               if (sts.idx_zero) begin
                  cmd.res_load = 1'b1;
                  state_in     = ST_OUT;
               end else begin
                  cmd.hi_load = 1'b1;
                  state_in    = ST_MUL;
               end
            end else if (sts.idx_last) begin
               cmd.res_load = 1'b1;
               state_in     = ST_OUT;
            end else begin
               cmd.idx_inc = 1'b1;
               cmd.lo_load = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = ST_DSTART;
         end
         ST_DSTART: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = icdf_pkg::RES_INTERP;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/inverse_cdf_interpolator.sv =====
// Top level of the inverse CDF interpolator: piecewise-linear quantile lookup
//
// Request words on req_*: tuser carries the opcode (append, query, clear),
// tdata the breakpoint value, its probability and the query probability.
// Append and clear give no response word. A query gives
// one response word on rsp_*: the quantile in tdata, the too-few-entries
// flag in tuser.
// Query path, accept to rsp_tvalid: the error case goes straight to the
// output register; a query at or beyond either end reads the first or last
// entry; otherwise a linear search through the breakpoint memory (one entry
// per cycle) stops at the first entry above the query, giving entry 0's
// value when that is the first entry and the last entry's value when none
// lies above; else come multiply, divider start, the bit-serial divider
// and the output register.
// One word is in flight at a time; the next is taken once the previous
// query has reached the output register.
// The response register holds its word while rsp_tready is low; a further
// query then waits after its division until the register is free.
// Reset empties the table and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module inverse_cdf_interpolator #(
   parameter int MAX_POINTS     = icdf_pkg::MAX_POINTS_DEF,
   parameter int PROB_FRAC_BITS = icdf_pkg::PROB_FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // point_value, point_prob, query_prob, zero fill
   input  wire logic [((icdf_pkg::VALUE_W + 2*PROB_FRAC_BITS + 4 + 7) / 8) * 8 - 1:0]
                                                       req_tdata,
   // opcode
   input  wire logic [icdf_pkg::OPCODE_W-1:0]          req_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // quantile
   output logic [icdf_pkg::VALUE_W-1:0]                rsp_tdata,
   // table_error
   output logic [0:0]                                  rsp_tuser
);

   localparam int VW = icdf_pkg::VALUE_W;
   localparam int PW = PROB_FRAC_BITS + 1;
   localparam int QW = PROB_FRAC_BITS + 3;

   icdf_pkg::cmd_type cmd;
   icdf_pkg::sts_type sts;
   logic              rsp_err;

   icdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   icdf_dp #(
      .MAX_POINTS     (MAX_POINTS),
      .PROB_FRAC_BITS (PROB_FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .point_value     (req_tdata[VW-1:0]),
      .point_prob      (req_tdata[VW+PW-1:VW]),
      .query_prob      ($signed(req_tdata[VW+PW+QW-1:VW+PW])),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_quantile    (rsp_tdata),
      .rsp_table_error (rsp_err)
   );

   assign rsp_tuser = rsp_err;

endmodule

`default_nettype wire

// ===== sim/inverse_cdf_interpolator_test.sv =====
// Self-checking testbench of the inverse CDF interpolator: predicted quantiles against rsp words
`timescale 1ns / 1ps

module inverse_cdf_interpolator_test;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int         PROB_ONE    = 1 << icdf_pkg::PROB_FRAC_BITS_DEF;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         DRAIN_CYCLES = icdf_pkg::MAX_POINTS_DEF + 64;
   localparam int         TDATA_W = ((icdf_pkg::VALUE_W + 2*icdf_pkg::PROB_FRAC_BITS_DEF
                                      + 4 + 7) / 8) * 8;

   typedef struct {
      logic [icdf_pkg::VALUE_W-1:0] quantile;
      logic                         table_error;
   } quantile_word_type;

   // Breakpoint table mirror and queue of quantiles still owed by the block
   class QuantileScoreboard;
      int                point_values[icdf_pkg::MAX_POINTS_DEF];
      int                point_probs[icdf_pkg::MAX_POINTS_DEF];
      int unsigned       entry_total;
      quantile_word_type owed_quantiles[$];

      function longint quantile_at(longint q);
         int unsigned i;
         longint      lo_v;
         longint      hi_v;
         longint      lo_p;
         longint      hi_p;
         if (q <= 0) return point_values[0];
         if (q >= PROB_ONE) return point_values[entry_total-1];
         i = 0;
         while (i < entry_total && point_probs[i] <= q) i++;
         if (i >= entry_total) return point_values[entry_total-1];
         if (i == 0) return point_values[0];
         lo_v = point_values[i-1];
         hi_v = point_values[i];
         lo_p = point_probs[i-1];
         hi_p = point_probs[i];
         return lo_v + ((hi_v - lo_v) * (q - lo_p)) / (hi_p - lo_p);
      endfunction

      function void note_word(logic [1:0] op, logic [31:0] pv, logic [16:0] pp,
                              logic [18:0] qp);
         quantile_word_type w;
         longint            q;
         case (op)
            icdf_pkg::OP_APPEND: begin
               if (entry_total < icdf_pkg::MAX_POINTS_DEF) begin
                  point_values[entry_total] = int'(pv);
                  point_probs[entry_total]  = int'(pp);
                  entry_total++;
               end
            end
            icdf_pkg::OP_CLEAR: entry_total = 0;
            icdf_pkg::OP_QUERY: begin
               if (entry_total < 2) begin
                  w.quantile    = '0;
                  w.table_error = 1'b1;
               end else begin
                  q             = $signed(qp);
                  w.quantile    = 32'(quantile_at(q));
                  w.table_error = 1'b0;
               end
               owed_quantiles.push_back(w);
            end
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return owed_quantiles.size();
      endfunction

      function string check(logic [31:0] quantile, logic table_error);
         quantile_word_type w;
         string             msg;
         msg = "";
         if (owed_quantiles.size() == 0)
            return $sformatf("rsp word %0d/%0b with no query waiting",
                             $signed(quantile), table_error);
         w = owed_quantiles.pop_front();
         if (quantile !== w.quantile)
            msg = $sformatf("quantile got %0d want %0d ", $signed(quantile),
                            $signed(w.quantile));
         if (table_error !== w.table_error)
            msg = {msg, $sformatf("table_error got %0b want %0b", table_error,
                                  w.table_error)};
         return msg;
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;   // point_value, point_prob, query_prob, zero fill
   logic [1:0]         req_tuser  = '0;   // opcode
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [31:0]        rsp_tdata;         // quantile
   logic [0:0]         rsp_tuser;         // table_error

   QuantileScoreboard sb;
   int                appended_probs[$];
   int                words_sent     = 0;
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   int                send_idle_pct  = 0;
   int                recv_idle_pct  = 0;
   int                target;

   inverse_cdf_interpolator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : rsp_side
      string msg;
      if (!reset && rsp_tvalid && rsp_tready) begin
         msg = sb.check(rsp_tdata, rsp_tuser[0]);
         if (msg != "") report_mismatch(msg);
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("inverse_cdf_interpolator_test: FAIL");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [31:0] pv,
                            input logic [16:0] pp, input logic [18:0] qp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, qp, pp, pv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(op, pv, pp, qp);
      if (op == icdf_pkg::OP_APPEND) appended_probs.push_back(int'(pp));
      else if (op == icdf_pkg::OP_CLEAR) appended_probs.delete();
      if (op != OP_RESERVED) words_sent++;
   endtask

   task automatic append_point(input int value, input int prob);
      send_word(icdf_pkg::OP_APPEND, value, 17'(prob), 19'($urandom));
   endtask

   task automatic query(input int prob);
      send_word(icdf_pkg::OP_QUERY, $urandom, 17'($urandom_range(0, PROB_ONE)), 19'(prob));
   endtask

   task automatic clear_table();
      send_word(icdf_pkg::OP_CLEAR, $urandom, 17'($urandom_range(0, PROB_ONE)),
                19'(int'($urandom_range(0, 3*PROB_ONE)) - PROB_ONE));
   endtask

   function automatic int random_query_prob();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55) return $urandom_range(0, PROB_ONE);
      if (sel < 70 && appended_probs.size() > 0)
         return appended_probs[$urandom_range(0, appended_probs.size()-1)]
                + int'($urandom_range(2)) - 1;
      if (sel < 85) return int'($urandom_range(0, 3*PROB_ONE)) - PROB_ONE;
      if (sel < 92) return int'($urandom_range(0, 4)) - 2;
      return PROB_ONE - 2 + int'($urandom_range(0, 4));
   endfunction

   task automatic build_table(input int n, input bit ascending);
      int step_max;
      int p;
      int v;
      step_max = (PROB_ONE / (n + 1)) * 2;
      p        = $urandom_range(0, step_max);
      v        = $urandom;
      for (int i = 0; i < n; i++) begin
         if (ascending) begin
            append_point(v, (p > PROB_ONE) ? PROB_ONE : p);
            p += $urandom_range(0, step_max);
            if ($urandom_range(1)) v = $urandom;
            else v = v + int'($urandom_range(0, 1 << 20));
         end else begin
            append_point($urandom, $urandom_range(0, PROB_ONE));
         end
      end
   endtask

   task automatic run_sequence();
      int kind;
      kind = $urandom_range(99);
      if (kind < 80) begin
         if ($urandom_range(9) < 7) clear_table();
         build_table($urandom_range(0, 10), 1'b1);
         repeat ($urandom_range(1, 6)) query(random_query_prob());
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 6))
            send_word(2'($urandom_range(3)), $urandom, 17'($urandom_range(0, PROB_ONE)),
                      19'(int'($urandom_range(0, 3*PROB_ONE)) - PROB_ONE));
      end else begin
         build_table($urandom_range(1, 6), 1'b0);
         repeat ($urandom_range(1, 4)) query(random_query_prob());
      end
   endtask

   initial begin
      sb = new;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 78;

      // empty and single-entry tables
      query(PROB_ONE / 2);
      append_point(32'h0001_0000, PROB_ONE / 4);
      query(PROB_ONE / 2);
      send_word(OP_RESERVED, $urandom, 17'(PROB_ONE), 19'(PROB_ONE));
      clear_table();

      // value extremes across the full probability span
      append_point(32'h8000_0000, 0);
      append_point(0, PROB_ONE / 2);
      append_point(32'h7FFF_FFFF, PROB_ONE);
      query(-PROB_ONE);
      query(0);
      query(2*PROB_ONE);
      query(PROB_ONE);
      query(PROB_ONE / 4);
      query(PROB_ONE / 2);
      query(3*PROB_ONE / 4);
      query(PROB_ONE - 1);
      clear_table();

      // first entry above q, none above q, out-of-order entry
      append_point(5, 100);
      append_point(-7, 200);
      query(50);
      query(300);
      append_point(9, 150);
      query(180);
      query(199);

      target = words_sent + 155;
      while (words_sent < target) run_sequence();

      send_idle_pct = 78;
      recv_idle_pct = 24;
      // fill beyond capacity: trailing appends dropped
      clear_table();
      build_table(icdf_pkg::MAX_POINTS_DEF + 2, 1'b1);
      query(PROB_ONE - 1);
      query(appended_probs[icdf_pkg::MAX_POINTS_DEF - 2]);
      query(random_query_prob());
      query(PROB_ONE);
      clear_table();
      target = words_sent + 155;
      while (words_sent < target) run_sequence();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      target = words_sent + 155;
      while (words_sent < target) run_sequence();
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("inverse_cdf_interpolator_test: PASS");
      end else begin
         $display("inverse_cdf_interpolator_test: FAIL");
      end
      $finish;
   end

endmodule
